// ----- rtl/core/vflf_pkg.sv -----
// Package for the vertex fetch limit fold block.
// Holds the sequencer state type and shared constants; no dependencies.
`default_nettype none
package vflf_pkg;

  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
  localparam int unsigned STEPS = 32;
  localparam logic [4:0] STEP_LAST = 5'(STEPS - 1);
  localparam int unsigned ACC_W = 35;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_CNT  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FOLD = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/vflf_attr_if.sv -----
// Attribute channel: valid/ready handshake with one attribute description.
// Depends on nothing.
`default_nettype none
interface vflf_attr_if;
  logic        valid;
  logic        ready;
  logic        buffer_bound;
  logic        location_used;
  logic [31:0] buffer_bytes;
  logic [31:0] attribute_offset;
  logic [15:0] stride;
  logic [5:0]  element_bytes;
  logic        instance_rate;
  logic [31:0] divisor;
  logic [4:0]  attribute_location;
  logic [4:0]  attribute_binding;
  logic        last;

  modport source (
    output valid, buffer_bound, location_used, buffer_bytes, attribute_offset, stride,
           element_bytes, instance_rate, divisor, attribute_location, attribute_binding,
           last,
    input  ready
  );
  modport sink (
    input  valid, buffer_bound, location_used, buffer_bytes, attribute_offset, stride,
           element_bytes, instance_rate, divisor, attribute_location, attribute_binding,
           last,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/core/vflf_limit_if.sv -----
// Limit channel: valid/ready handshake carrying the folded vertex and instance limits.
// Depends on nothing.
`default_nettype none
interface vflf_limit_if;
  logic        valid;
  logic        ready;
  logic        vertex_limit_valid;
  logic [31:0] vertex_limit;
  logic [4:0]  vertex_limit_location;
  logic [4:0]  vertex_limit_binding;
  logic        instance_limit_valid;
  logic [31:0] instance_limit;
  logic [4:0]  instance_limit_location;
  logic [4:0]  instance_limit_binding;
  logic [31:0] instance_limit_divisor;

  modport source (
    output valid, vertex_limit_valid, vertex_limit, vertex_limit_location,
           vertex_limit_binding, instance_limit_valid, instance_limit,
           instance_limit_location, instance_limit_binding, instance_limit_divisor,
    input  ready
  );
  modport sink (
    input  valid, vertex_limit_valid, vertex_limit, vertex_limit_location,
           vertex_limit_binding, instance_limit_valid, instance_limit,
           instance_limit_location, instance_limit_binding, instance_limit_divisor,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/core/vertex_fetch_limit_fold_top.sv -----
// Vertex fetch limit fold: element count per attribute, running minima per input rate.
// Depends on vflf_pkg, vflf_attr_if and vflf_limit_if.
//
//   channel  dir  contents
//   attr     in   one attribute description, last marks the end of the draw
//   limit    out  vertex and instance limits, one transfer per last attribute
//
// Per attribute: a skipped or zero-stride one goes straight to the fold; per-vertex runs 32 divide steps,
// per-instance 32 divide steps plus 32 multiply steps, all on one shared 35-bit adder.
// Reset clears the minima and the output valid flag; the first attribute is taken right after.
// A result waiting on limit does not block attr; only a last attribute whose fold finds
// the output register still full holds until that transfer.
`default_nettype none
module vertex_fetch_limit_fold_top (
  input  wire          clk,
  input  wire          rst,
  vflf_attr_if.sink    attr,
  vflf_limit_if.source limit
);

  vflf_pkg::state_t state;
  logic [4:0]  step;
  logic [31:0] dvd;
  logic [15:0] rmd;
  logic [32:0] cnt;
  logic [vflf_pkg::ACC_W-1:0] acc;
  logic        ovf;

  logic        take_r;
  logic        inst_r;
  logic        last_r;
  logic [15:0] stride_r;
  logic [5:0]  asize_r;
  logic [31:0] div_r;
  logic [4:0]  loc_r;
  logic [4:0]  bnd_r;

  logic        vertex_seen;
  logic [31:0] vertex_min;
  logic [4:0]  vertex_min_location;
  logic [4:0]  vertex_min_binding;
  logic        instance_seen;
  logic [31:0] instance_min;
  logic [4:0]  instance_min_location;
  logic [4:0]  instance_min_binding;
  logic [31:0] instance_min_divisor;

  logic        vertex_seen_next;
  logic [31:0] vertex_min_next;
  logic [4:0]  vertex_min_location_next;
  logic [4:0]  vertex_min_binding_next;
  logic        instance_seen_next;
  logic [31:0] instance_min_next;
  logic [4:0]  instance_min_location_next;
  logic [4:0]  instance_min_binding_next;
  logic [31:0] instance_min_divisor_next;

  logic        out_valid;
  logic        o_vvalid;
  logic [31:0] o_vlimit;
  logic [4:0]  o_vloc;
  logic [4:0]  o_vbnd;
  logic        o_ivalid;
  logic [31:0] o_ilimit;
  logic [4:0]  o_iloc;
  logic [4:0]  o_ibnd;
  logic [31:0] o_idiv;

  logic [vflf_pkg::ACC_W-1:0] add_a;
  logic [vflf_pkg::ACC_W-1:0] add_b;
  logic        add_cin;
  logic [vflf_pkg::ACC_W-1:0] sum;
  logic [16:0] rtrial;
  logic [31:0] rem_in;
  logic [31:0] fold_v;
  logic        in_xfer;
  logic        out_xfer;
  logic        fold_fire;

  assign in_xfer  = attr.valid && attr.ready;
  assign out_xfer = limit.valid && limit.ready;
  assign attr.ready = (state == vflf_pkg::ST_IDLE);

  assign rem_in = (attr.buffer_bytes > attr.attribute_offset) ?
                  (attr.buffer_bytes - attr.attribute_offset) : 32'd0;
  assign rtrial = {rmd, dvd[31]};

  // shared adder: trial subtract while dividing, shift-add while multiplying
  always_comb begin
    case (state)
      vflf_pkg::ST_DIV: begin
        add_a   = {{(vflf_pkg::ACC_W-17){1'b0}}, rtrial};
        add_b   = ~{{(vflf_pkg::ACC_W-16){1'b0}}, stride_r};
        add_cin = 1'b1;
      end
      vflf_pkg::ST_MUL: begin
        add_a   = {acc[vflf_pkg::ACC_W-2:0], 1'b0};
        add_b   = dvd[31] ? {2'b00, cnt} : '0;
        add_cin = 1'b0;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end
  assign sum = add_a + add_b + {{(vflf_pkg::ACC_W-1){1'b0}}, add_cin};

  always_comb begin
    if (inst_r) begin
      fold_v = (ovf || (|acc[vflf_pkg::ACC_W-1:32])) ? vflf_pkg::ALL32 : acc[31:0];
    end else begin
      fold_v = cnt[32] ? vflf_pkg::ALL32 : cnt[31:0];
    end
  end

  always_comb begin
    vertex_seen_next          = vertex_seen;
    vertex_min_next           = vertex_min;
    vertex_min_location_next  = vertex_min_location;
    vertex_min_binding_next   = vertex_min_binding;
    instance_seen_next        = instance_seen;
    instance_min_next         = instance_min;
    instance_min_location_next = instance_min_location;
    instance_min_binding_next = instance_min_binding;
    instance_min_divisor_next = instance_min_divisor;
    if (take_r) begin
      if (!inst_r) begin
        vertex_seen_next = 1'b1;
        if (fold_v <= vertex_min) begin
          vertex_min_next          = fold_v;
          vertex_min_location_next = loc_r;
          vertex_min_binding_next  = bnd_r;
        end
      end else begin
        instance_seen_next = 1'b1;
        if (fold_v <= instance_min) begin
          instance_min_next          = fold_v;
          instance_min_location_next = loc_r;
          instance_min_binding_next  = bnd_r;
          instance_min_divisor_next  = div_r;
        end
      end
    end
  end

  assign fold_fire = (state == vflf_pkg::ST_FOLD) && (!last_r || !out_valid || limit.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= vflf_pkg::ST_IDLE;
      step                  <= '0;
      out_valid             <= 1'b0;
      vertex_seen           <= 1'b0;
      vertex_min            <= vflf_pkg::ALL32;
      vertex_min_location   <= '0;
      vertex_min_binding    <= '0;
      instance_seen         <= 1'b0;
      instance_min          <= vflf_pkg::ALL32;
      instance_min_location <= '0;
      instance_min_binding  <= '0;
      instance_min_divisor  <= vflf_pkg::ALL32;
    end else begin
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        vflf_pkg::ST_IDLE: begin
          if (in_xfer) begin
            inst_r   <= attr.instance_rate;
            last_r   <= attr.last;
            stride_r <= attr.stride;
            asize_r  <= attr.element_bytes;
            div_r    <= attr.divisor;
            loc_r    <= attr.attribute_location;
            bnd_r    <= attr.attribute_binding;
            cnt      <= '0;
            acc      <= '0;
            ovf      <= 1'b0;
            rmd      <= '0;
            dvd      <= rem_in;
            step     <= '0;
            if (!(attr.buffer_bound && attr.location_used)) begin
              take_r <= 1'b0;
              state  <= vflf_pkg::ST_FOLD;
            end else if (attr.stride == 16'd0) begin
              take_r <= (rem_in < {26'd0, attr.element_bytes});
              state  <= vflf_pkg::ST_FOLD;
            end else begin
              take_r <= 1'b1;
              state  <= vflf_pkg::ST_DIV;
            end
          end
        end
        vflf_pkg::ST_DIV: begin
          if (!sum[vflf_pkg::ACC_W-1]) begin
            rmd <= sum[15:0];
            dvd <= {dvd[30:0], 1'b1};
          end else begin
            rmd <= rtrial[15:0];
            dvd <= {dvd[30:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == vflf_pkg::STEP_LAST) begin
            state <= vflf_pkg::ST_CNT;
          end
        end
        vflf_pkg::ST_CNT: begin
          cnt  <= {1'b0, dvd} + {32'd0, (rmd >= {10'd0, asize_r})};
          step <= '0;
          if (inst_r) begin
            dvd   <= div_r;
            acc   <= '0;
            ovf   <= 1'b0;
            state <= vflf_pkg::ST_MUL;
          end else begin
            state <= vflf_pkg::ST_FOLD;
          end
        end
        vflf_pkg::ST_MUL: begin
          acc  <= sum;
          ovf  <= ovf | (|sum[vflf_pkg::ACC_W-1:32]);
          dvd  <= {dvd[30:0], 1'b0};
          step <= step + 5'd1;
          if (step == vflf_pkg::STEP_LAST) begin
            state <= vflf_pkg::ST_FOLD;
          end
        end
        vflf_pkg::ST_FOLD: begin
          if (fold_fire) begin
            state <= vflf_pkg::ST_IDLE;
            if (last_r) begin
              out_valid             <= 1'b1;
              vertex_seen           <= 1'b0;
              vertex_min            <= vflf_pkg::ALL32;
              vertex_min_location   <= '0;
              vertex_min_binding    <= '0;
              instance_seen         <= 1'b0;
              instance_min          <= vflf_pkg::ALL32;
              instance_min_location <= '0;
              instance_min_binding  <= '0;
              instance_min_divisor  <= vflf_pkg::ALL32;
            end else begin
              vertex_seen           <= vertex_seen_next;
              vertex_min            <= vertex_min_next;
              vertex_min_location   <= vertex_min_location_next;
              vertex_min_binding    <= vertex_min_binding_next;
              instance_seen         <= instance_seen_next;
              instance_min          <= instance_min_next;
              instance_min_location <= instance_min_location_next;
              instance_min_binding  <= instance_min_binding_next;
              instance_min_divisor  <= instance_min_divisor_next;
            end
          end
        end
        default: begin
          state <= vflf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // output payload, zeroed where no attribute of that rate contributed
  always_ff @(posedge clk) begin
    if (fold_fire && last_r) begin
      o_vvalid <= vertex_seen_next;
      o_vlimit <= vertex_seen_next ? vertex_min_next : 32'd0;
      o_vloc   <= vertex_seen_next ? vertex_min_location_next : 5'd0;
      o_vbnd   <= vertex_seen_next ? vertex_min_binding_next : 5'd0;
      o_ivalid <= instance_seen_next;
      o_ilimit <= instance_seen_next ? instance_min_next : 32'd0;
      o_iloc   <= instance_seen_next ? instance_min_location_next : 5'd0;
      o_ibnd   <= instance_seen_next ? instance_min_binding_next : 5'd0;
      o_idiv   <= instance_seen_next ? instance_min_divisor_next : 32'd0;
    end
  end

  assign limit.valid                   = out_valid;
  assign limit.vertex_limit_valid      = o_vvalid;
  assign limit.vertex_limit            = o_vlimit;
  assign limit.vertex_limit_location   = o_vloc;
  assign limit.vertex_limit_binding    = o_vbnd;
  assign limit.instance_limit_valid    = o_ivalid;
  assign limit.instance_limit          = o_ilimit;
  assign limit.instance_limit_location = o_iloc;
  assign limit.instance_limit_binding  = o_ibnd;
  assign limit.instance_limit_divisor  = o_idiv;

  a_div_rem_below_stride: assert property (@(posedge clk) disable iff (rst)
    (state == vflf_pkg::ST_DIV) && (step == vflf_pkg::STEP_LAST) |=> (rmd < stride_r))
    else $error("divide remainder not below stride");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == vflf_pkg::ST_CNT) |=> (state == vflf_pkg::ST_MUL) || (state == vflf_pkg::ST_FOLD))
    else $error("count step did not advance to multiply or fold");

  a_vertex_unseen_min: assert property (@(posedge clk) disable iff (rst)
    !vertex_seen |-> (vertex_min == vflf_pkg::ALL32))
    else $error("vertex minimum moved without a contributing attribute");

  a_instance_unseen_min: assert property (@(posedge clk) disable iff (rst)
    !instance_seen |-> (instance_min == vflf_pkg::ALL32))
    else $error("instance minimum moved without a contributing attribute");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !o_ivalid |-> (o_ilimit == 32'd0) && (o_idiv == 32'd0))
    else $error("instance limit not zeroed when invalid");

endmodule
`default_nettype wire

// ----- tb/tb_vertex_fetch_limit_fold_top.sv -----
`timescale 1ns / 1ps
// Testbench for vertex_fetch_limit_fold_top: drives attribute descriptions, predicts the
// per-draw vertex and instance limits and checks every limit transfer.
// Depends on vflf_pkg, vflf_attr_if, vflf_limit_if and the block itself.
module tb_vertex_fetch_limit_fold_top;

  localparam bit RATE_VERTEX   = 1'b0;
  localparam bit RATE_INSTANCE = 1'b1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 600;
  localparam int TAIL_CYCLES    = 100;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    bit        buffer_bound;
    bit        location_used;
    bit [31:0] buffer_bytes;
    bit [31:0] attribute_offset;
    bit [15:0] stride;
    bit [5:0]  element_bytes;
    bit        instance_rate;
    bit [31:0] divisor;
    bit [4:0]  attribute_location;
    bit [4:0]  attribute_binding;
    bit        last;
  } attr_item_t;

  typedef struct packed {
    bit        vertex_limit_valid;
    bit [31:0] vertex_limit;
    bit [4:0]  vertex_limit_location;
    bit [4:0]  vertex_limit_binding;
    bit        instance_limit_valid;
    bit [31:0] instance_limit;
    bit [4:0]  instance_limit_location;
    bit [4:0]  instance_limit_binding;
    bit [31:0] instance_limit_divisor;
  } limit_item_t;

  typedef struct packed {
    bit        vtx_seen;
    bit [31:0] vtx_min;
    bit [4:0]  vtx_loc;
    bit [4:0]  vtx_bnd;
    bit        inst_seen;
    bit [31:0] inst_min;
    bit [4:0]  inst_loc;
    bit [4:0]  inst_bnd;
    bit [31:0] inst_div;
  } minima_t;

  localparam minima_t MINIMA_RESET = '{vtx_seen: 1'b0, vtx_min: vflf_pkg::ALL32,
                                       vtx_loc: 5'd0, vtx_bnd: 5'd0, inst_seen: 1'b0,
                                       inst_min: vflf_pkg::ALL32, inst_loc: 5'd0,
                                       inst_bnd: 5'd0, inst_div: vflf_pkg::ALL32};

  logic clk = 1'b0;
  logic rst = 1'b1;

  vflf_attr_if  attr_ch ();
  vflf_limit_if limit_ch ();

  vertex_fetch_limit_fold_top i_dut (
    .clk   (clk),
    .rst   (rst),
    .attr  (attr_ch),
    .limit (limit_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  attr_item_t  pending_attrs[$];
  limit_item_t expected_limits[$];
  minima_t     draw_minima = MINIMA_RESET;
  idle_mode_t  idle_mode = IDLE_NONE;
  int          error_count = 0;
  int          quiet_cycles = 0;
  bit          attr_fire = 1'b0;
  bit          holdoff_go = 1'b0;
  bit          holdoff_done = 1'b0;
  int          holdoff_count = 0;

  function automatic bit [31:0] saturate(input logic [63:0] value);
    return (value > 64'(vflf_pkg::ALL32)) ? vflf_pkg::ALL32 : value[31:0];
  endfunction

  function automatic void fold_attribute(input attr_item_t a, output bit emit,
                                         output limit_item_t res);
    logic [63:0] rem;
    logic [63:0] count;
    bit [31:0]   capped;
    bit          take;
    emit = 1'b0;
    res = '0;
    if (a.buffer_bound && a.location_used) begin
      rem = (a.buffer_bytes > a.attribute_offset) ?
            64'(a.buffer_bytes - a.attribute_offset) : 64'd0;
      count = 64'd0;
      take = 1'b1;
      if (a.stride != 16'd0) begin
        count = rem / 64'(a.stride);
        if (rem - count * 64'(a.stride) >= 64'(a.element_bytes)) count = count + 64'd1;
      end else if (rem >= 64'(a.element_bytes)) begin
        take = 1'b0;
      end
      if (take && a.instance_rate == RATE_VERTEX) begin
        capped = saturate(count);
        draw_minima.vtx_seen = 1'b1;
        if (capped <= draw_minima.vtx_min) begin
          draw_minima.vtx_min = capped;
          draw_minima.vtx_loc = a.attribute_location;
          draw_minima.vtx_bnd = a.attribute_binding;
        end
      end else if (take) begin
        capped = saturate(count * 64'(a.divisor));
        draw_minima.inst_seen = 1'b1;
        if (capped <= draw_minima.inst_min) begin
          draw_minima.inst_min = capped;
          draw_minima.inst_loc = a.attribute_location;
          draw_minima.inst_bnd = a.attribute_binding;
          draw_minima.inst_div = a.divisor;
        end
      end
    end
    if (a.last) begin
      emit = 1'b1;
      if (draw_minima.vtx_seen) begin
        res.vertex_limit_valid    = 1'b1;
        res.vertex_limit          = draw_minima.vtx_min;
        res.vertex_limit_location = draw_minima.vtx_loc;
        res.vertex_limit_binding  = draw_minima.vtx_bnd;
      end
      if (draw_minima.inst_seen) begin
        res.instance_limit_valid    = 1'b1;
        res.instance_limit          = draw_minima.inst_min;
        res.instance_limit_location = draw_minima.inst_loc;
        res.instance_limit_binding  = draw_minima.inst_bnd;
        res.instance_limit_divisor  = draw_minima.inst_div;
      end
      draw_minima = MINIMA_RESET;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic bit percent(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return percent(65);
      IDLE_BOTH:   return percent(9);
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return percent(65);
      IDLE_BOTH:     return percent(9);
      default:       return 1'b0;
    endcase
  endfunction

  // Predict on every attribute transfer, check every limit transfer, watch for a hang.
  always @(posedge clk) begin
    bit          emit;
    limit_item_t want;
    if (rst) begin
      attr_fire    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      attr_fire <= attr_ch.valid && attr_ch.ready;
      if (attr_ch.valid && attr_ch.ready) begin
        fold_attribute(pending_attrs.pop_front(), emit, want);
        if (emit) expected_limits.push_back(want);
      end
      if (limit_ch.valid && limit_ch.ready) begin
        if (expected_limits.size() == 0) begin
          $error("limit transfer with no result expected");
          error_count++;
        end else begin
          want = expected_limits.pop_front();
          compare_field("vertex_limit_valid", want.vertex_limit_valid,
                        limit_ch.vertex_limit_valid);
          compare_field("vertex_limit", want.vertex_limit, limit_ch.vertex_limit);
          compare_field("vertex_limit_location", want.vertex_limit_location,
                        limit_ch.vertex_limit_location);
          compare_field("vertex_limit_binding", want.vertex_limit_binding,
                        limit_ch.vertex_limit_binding);
          compare_field("instance_limit_valid", want.instance_limit_valid,
                        limit_ch.instance_limit_valid);
          compare_field("instance_limit", want.instance_limit, limit_ch.instance_limit);
          compare_field("instance_limit_location", want.instance_limit_location,
                        limit_ch.instance_limit_location);
          compare_field("instance_limit_binding", want.instance_limit_binding,
                        limit_ch.instance_limit_binding);
          compare_field("instance_limit_divisor", want.instance_limit_divisor,
                        limit_ch.instance_limit_divisor);
        end
      end
      if ((attr_ch.valid && attr_ch.ready) || (limit_ch.valid && limit_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Attribute driver: hold the offered item until its transfer, then advance.
  always @(negedge clk) begin
    if (rst) begin
      attr_ch.valid <= 1'b0;
    end else if (!attr_ch.valid || attr_fire) begin
      if (pending_attrs.size() != 0 && !sender_idles()) begin
        attr_ch.valid              <= 1'b1;
        attr_ch.buffer_bound       <= pending_attrs[0].buffer_bound;
        attr_ch.location_used      <= pending_attrs[0].location_used;
        attr_ch.buffer_bytes       <= pending_attrs[0].buffer_bytes;
        attr_ch.attribute_offset   <= pending_attrs[0].attribute_offset;
        attr_ch.stride             <= pending_attrs[0].stride;
        attr_ch.element_bytes      <= pending_attrs[0].element_bytes;
        attr_ch.instance_rate      <= pending_attrs[0].instance_rate;
        attr_ch.divisor            <= pending_attrs[0].divisor;
        attr_ch.attribute_location <= pending_attrs[0].attribute_location;
        attr_ch.attribute_binding  <= pending_attrs[0].attribute_binding;
        attr_ch.last               <= pending_attrs[0].last;
      end else begin
        attr_ch.valid <= 1'b0;
      end
    end
  end

  // Limit receiver: one long hold-off when requested, random stalls otherwise.
  always @(negedge clk) begin
    if (rst) begin
      limit_ch.ready <= 1'b0;
    end else if (holdoff_go && !holdoff_done) begin
      limit_ch.ready <= 1'b0;
      if (holdoff_count == HOLD_CYCLES - 1) holdoff_done <= 1'b1;
      holdoff_count <= holdoff_count + 1;
    end else begin
      limit_ch.ready <= !receiver_stalls();
    end
  end

  task automatic push_attr(input bit bound, input bit used, input bit [31:0] size,
                           input bit [31:0] offs, input bit [15:0] stride,
                           input bit [5:0] asize, input bit rate, input bit [31:0] div,
                           input bit [4:0] loc, input bit [4:0] bnd, input bit last);
    pending_attrs.push_back('{bound, used, size, offs, stride, asize, rate, div, loc, bnd,
                              last});
  endtask

  function automatic attr_item_t random_attr(input bit is_last);
    attr_item_t a;
    a.buffer_bound  = percent(92);
    a.location_used = percent(92);
    case ($urandom_range(0, 3))
      0:       a.buffer_bytes = $urandom;
      1:       a.buffer_bytes = $urandom_range(0, 4096);
      2:       a.buffer_bytes = $urandom_range(0, 255);
      default: a.buffer_bytes = vflf_pkg::ALL32 - $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 9))
      0, 1:    a.attribute_offset = $urandom;
      2:       a.attribute_offset = a.buffer_bytes + $urandom_range(0, 8) - 4;
      default: a.attribute_offset = $urandom_range(0, 64);
    endcase
    case ($urandom_range(0, 9))
      0:       a.stride = 16'd0;
      1, 2:    a.stride = 16'(32'hFFFF - $urandom_range(0, 63));
      3, 4:    a.stride = 16'($urandom_range(0, 65535));
      default: a.stride = 16'($urandom_range(1, 64));
    endcase
    a.element_bytes = percent(85) ? 6'($urandom_range(1, 32)) : 6'($urandom_range(0, 63));
    a.instance_rate = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0:       a.divisor = 32'd0;
      1:       a.divisor = 32'd1;
      2:       a.divisor = $urandom;
      3:       a.divisor = vflf_pkg::ALL32;
      default: a.divisor = $urandom_range(1, 16);
    endcase
    a.attribute_location = 5'($urandom_range(0, 31));
    a.attribute_binding  = 5'($urandom_range(0, 31));
    a.last = is_last;
    return a;
  endfunction

  task automatic push_random_draws(input int n_items);
    int         counted;
    int         len;
    attr_item_t a;
    counted = 0;
    while (counted < n_items) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        a = random_attr(i == len - 1);
        pending_attrs.push_back(a);
        counted++;
      end
    end
  endtask

  task automatic wait_for_drain();
    while (pending_attrs.size() != 0 || expected_limits.size() != 0) @(posedge clk);
  endtask

  initial begin
    attr_ch.valid              = 1'b0;
    attr_ch.buffer_bound       = 1'b0;
    attr_ch.location_used      = 1'b0;
    attr_ch.buffer_bytes       = '0;
    attr_ch.attribute_offset   = '0;
    attr_ch.stride             = '0;
    attr_ch.element_bytes      = '0;
    attr_ch.instance_rate      = 1'b0;
    attr_ch.divisor            = '0;
    attr_ch.attribute_location = '0;
    attr_ch.attribute_binding  = '0;
    attr_ch.last               = 1'b0;
    limit_ch.ready             = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unbound last alone: empty result
    push_attr(0, 1, 32'd100, 0, 4, 4, RATE_VERTEX, 1, 1, 1, 1);
    push_attr(1, 0, 32'd100, 0, 4, 4, RATE_INSTANCE, 1, 2, 2, 0);
    // saturation on both rates
    push_attr(1, 1, vflf_pkg::ALL32, 0, 1, 0, RATE_VERTEX, 0, 31, 31, 0);
    push_attr(1, 1, vflf_pkg::ALL32, 0, 1, 0, RATE_INSTANCE, vflf_pkg::ALL32, 0, 31, 1);
    // offset at or past the size, zero stride skipped and zero stride too small
    push_attr(1, 1, 32'd100, 32'd100, 16, 4, RATE_VERTEX, 0, 3, 1, 0);
    push_attr(1, 1, 32'd100, 32'd200, 16'hFFFF, 0, RATE_VERTEX, 0, 4, 1, 0);
    push_attr(1, 1, 32'd64, 0, 0, 32, RATE_INSTANCE, 5, 5, 1, 0);
    push_attr(1, 1, 32'd16, 0, 0, 32, RATE_INSTANCE, 7, 6, 1, 1);
    // ties go to the later attribute
    push_attr(1, 1, 32'd1000, 0, 10, 4, RATE_VERTEX, 0, 7, 2, 0);
    push_attr(1, 1, 32'd1004, 4, 10, 4, RATE_VERTEX, 0, 8, 3, 0);
    push_attr(1, 1, 32'd400, 0, 4, 4, RATE_INSTANCE, 3, 9, 4, 0);
    push_attr(1, 1, 32'd150, 0, 1, 1, RATE_INSTANCE, 2, 10, 4, 1);
    // zero divisor
    push_attr(1, 1, 32'd4096, 0, 16, 16, RATE_INSTANCE, 0, 11, 5, 1);
    // out of range sizes, widest stride
    push_attr(1, 1, 32'd1000, 0, 100, 63, RATE_VERTEX, 0, 12, 6, 0);
    push_attr(1, 1, 32'd65568, 0, 16'hFFFF, 33, RATE_VERTEX, 0, 13, 7, 1);
    push_attr(1, 1, vflf_pkg::ALL32, vflf_pkg::ALL32, 0, 0, RATE_VERTEX, 0, 14, 8, 1);
    // skipped last after a contributing attribute
    push_attr(1, 1, 32'd50, 0, 8, 8, RATE_VERTEX, 0, 15, 9, 0);
    push_attr(0, 0, 32'd50, 0, 8, 8, RATE_INSTANCE, 9, 16, 10, 1);
    wait_for_drain();

    holdoff_go = 1'b1;
    push_random_draws(260);
    wait_for_drain();
    idle_mode = IDLE_SENDER;
    push_random_draws(260);
    wait_for_drain();
    idle_mode = IDLE_RECEIVER;
    push_random_draws(260);
    wait_for_drain();
    idle_mode = IDLE_BOTH;
    push_random_draws(260);
    wait_for_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/vflf_pkg.sv
rtl/core/vflf_attr_if.sv
rtl/core/vflf_limit_if.sv
rtl/core/vertex_fetch_limit_fold_top.sv
tb/tb_vertex_fetch_limit_fold_top.sv
